/* src/dtr_pkg.sv */
// Shared types, codes and helpers for the divider timer with reload.
// No dependencies; the unit, core and output buffer files import this package.
`timescale 1ns / 1ps

package dtr_pkg;

  // Item kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    KindTick  = 2'd0,
    KindRead  = 2'd1,
    KindWrite = 2'd2
  } kind_e;

  // Register selector codes.
  typedef enum logic [1:0] {
    SelDivider = 2'd0,
    SelCounter = 2'd1,
    SelModulo  = 2'd2,
    SelControl = 2'd3
  } sel_e;

  localparam int unsigned DivWidth      = 16;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned CtrlEnableBit = 2;

  // One input word after unpacking.
  typedef struct packed {
    logic [1:0]           kind;
    logic [1:0]           reg_select;
    logic [ByteWidth-1:0] write_data;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [ByteWidth-1:0] read_data;
    logic                 timer_interrupt;
  } result_t;

  // Divider bit watched for falling edges, chosen by the control speed field.
  function automatic logic [3:0] tap_index(input logic [1:0] speed);
    logic [3:0] idx;
    case (speed)
      2'd0:    idx = 4'd9;
      2'd1:    idx = 4'd3;
      2'd2:    idx = 4'd5;
      default: idx = 4'd7;
    endcase
    return idx;
  endfunction

endpackage

/* src/divider_timer_with_reload_unit.sv */
// An accepted word is held in the input register, and its result is written to the
// result buffer, from which the output stream reads it.
// Throughput: one word per cycle while results are taken; the two-entry result buffer
// keeps input open while a result waits; input stalls only when both entries are full.
// Reset (rst_ni, asynchronous, active low) clears divider, counter, modulo, control
// and all valid state. Depends on dtr_pkg, dtr_core and dtr_out_buf.
`timescale 1ns / 1ps

module divider_timer_with_reload_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [1:0] reg_select, [9:2] write_data, rest zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [7:0] read_data, [8] timer_interrupt, rest zero
);
  import dtr_pkg::*;

  // Input register: the accepted word waits here until the result buffer has room, then
  // the core applies it to the timer state and its result is written to the buffer.
  logic    in_valid_q, in_valid_d;
  item_t   item_q;
  logic    s_accept;
  logic    advance;
  logic    can_push;
  result_t core_result;
  result_t out_result;

  // The held word moves on whenever the result buffer has room this cycle.
  assign advance         = in_valid_q & can_push;
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q.kind       <= s_axis_tuser_i;
      item_q.reg_select <= s_axis_tdata_i[1:0];
      item_q.write_data <= s_axis_tdata_i[9:2];
    end
  end

  // Timer state and the single-pass update for one word.
  dtr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (item_q),
    .result_o (core_result)
  );

  // Result register with a skid entry toward the output stream.
  dtr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .push_data_i (core_result),
    .can_push_o  (can_push),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (out_result)
  );

  assign m_axis_tdata_o = {7'd0, out_result.timer_interrupt, out_result.read_data};

endmodule

/* src/dtr_core.sv */
// Timer state (divider, counter, modulo, control) and the per-word update.
// Depends on dtr_pkg.
`timescale 1ns / 1ps

module dtr_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  dtr_pkg::item_t  item_i,
  output dtr_pkg::result_t result_o
);
  import dtr_pkg::*;

  logic [DivWidth-1:0]  div_q, div_d;
  logic [ByteWidth-1:0] cnt_q, cnt_d;
  logic [ByteWidth-1:0] mod_q, mod_d;
  logic [ByteWidth-1:0] ctrl_q, ctrl_d;

  logic [DivWidth-1:0]  div_inc;
  logic [3:0]           tap;
  logic                 fall;
  logic [ByteWidth:0]   cnt_inc;

  assign div_inc = div_q + DivWidth'(1);
  assign tap     = tap_index(ctrl_q[1:0]);
  // A falling edge on the tap bit across this tick.
  assign fall    = div_q[tap] & ~div_inc[tap];
  assign cnt_inc = {1'b0, cnt_q} + (ByteWidth+1)'(1);

  always_comb begin
    div_d    = div_q;
    cnt_d    = cnt_q;
    mod_d    = mod_q;
    ctrl_d   = ctrl_q;
    result_o = '0;
    if (en_i) begin
      case (item_i.kind)
        KindTick: begin
          div_d = div_inc;
          if (ctrl_q[CtrlEnableBit] && fall) begin
            if (cnt_inc[ByteWidth]) begin
              cnt_d                    = mod_q;
              result_o.timer_interrupt = 1'b1;
            end else begin
              cnt_d = cnt_inc[ByteWidth-1:0];
            end
          end
        end
        KindRead: begin
          case (item_i.reg_select)
            SelDivider: result_o.read_data = div_q[DivWidth-1 -: ByteWidth];
            SelCounter: result_o.read_data = cnt_q;
            SelModulo:  result_o.read_data = mod_q;
            default:    result_o.read_data = ctrl_q;
          endcase
        end
        KindWrite: begin
          case (item_i.reg_select)
            SelDivider: div_d  = '0;
            SelCounter: cnt_d  = item_i.write_data;
            SelModulo:  mod_d  = item_i.write_data;
            default:    ctrl_d = item_i.write_data;
          endcase
        end
        default: begin
          div_d = div_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q  <= '0;
      cnt_q  <= '0;
      mod_q  <= '0;
      ctrl_q <= '0;
    end else begin
      div_q  <= div_d;
      cnt_q  <= cnt_d;
      mod_q  <= mod_d;
      ctrl_q <= ctrl_d;
    end
  end

endmodule

/* src/dtr_out_buf.sv */
// Two-entry result buffer that decouples the core from the output stream.
// Depends on dtr_pkg.
`timescale 1ns / 1ps

module dtr_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dtr_pkg::result_t  push_data_i,
  output logic              can_push_o,
  output logic              valid_o,
  input  logic              ready_i,
  output dtr_pkg::result_t  data_o
);
  import dtr_pkg::*;

  result_t    entry_q [2];
  logic       rd_ptr_q, rd_ptr_d;
  logic       wr_ptr_q, wr_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o    = (count_q != 2'd0);
  assign pop        = valid_o & ready_i;
  assign can_push_o = (count_q != 2'd2) | pop;
  assign data_o     = entry_q[rd_ptr_q];

  always_comb begin
    rd_ptr_d = rd_ptr_q ^ pop;
    wr_ptr_d = wr_ptr_q ^ push_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* src/dtr_checker.sv */
// Port-level checks for the divider timer with reload, bound to the top level.
// Depends on divider_timer_with_reload_unit.
`timescale 1ns / 1ps

module dtr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // Input is only held off when a result is backed up at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled without a pending result");

  // An interrupt result never carries read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[8]) |-> (m_axis_tdata_o[7:0] == 8'd0))
    else $error("interrupt result with nonzero read data");

  // Padding bits of the result stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[15:9] == 7'd0))
    else $error("result padding bits set");

  // No result appears without an earlier accepted word: empty after reset.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid straight out of reset");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind divider_timer_with_reload_unit dtr_checker u_dtr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
